@@ design/udiv_pkg.sv @@
`timescale 1ns / 1ps

package udiv_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    localparam logic [4:0] POS_MAX     = 5'd20;
    localparam logic [4:0] POS_SHORT   = 5'd19;
    localparam logic [4:0] POS_SIZE    = 5'd4;
    localparam logic [4:0] POS_VERSION = 5'd8;
    localparam logic [4:0] POS_CYL     = 5'd9;
    localparam logic [4:0] POS_SIDE    = 5'd10;

    typedef enum logic [1:0] {
        ST_GOOD      = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_SHORT     = 2'd2,
        ST_BAD_MAGIC = 2'd3
    } udiv_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } udiv_in_t;

    typedef struct packed {
        udiv_status_t status;
        logic [7:0]   format_version;
        logic [7:0]   cylinder_count;
        logic [7:0]   side_count;
        logic [31:0]  declared_size;
        logic [31:0]  checksum_stored;
        logic [31:0]  checksum_computed;
    } udiv_out_t;

    // "UDI!" in file order
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h55;
            2'd1:    m = 8'h44;
            2'd2:    m = 8'h49;
            default: m = 8'h21;
        endcase
        return m;
    endfunction

    // complemented reflected byte step, complemented again on exit
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ CRC_ONES ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c ^ CRC_ONES;
    endfunction

endpackage

@@ design/udi_image_verifier.sv @@
`timescale 1ns / 1ps

// channel   valid          stall          payload
// input     byte_valid     byte_stall     byte_data  (one image byte)
// output    report_valid   report_stall   report     (one per image)
//
// One byte per cycle unless a final byte waits behind a stalled report;
// the CRC byte step is unrolled between the delay line and the
// state/report registers. The final byte passes the input register,
// then its report is registered, held up only behind a stalled report.
// Reset clears count and valid flags, fills CRC with ones, sets magic.
// byte_stall rises only when a final byte waits behind a stalled report.
module udi_image_verifier (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  udiv_pkg::udiv_in_t  byte_data,
    output logic                report_valid,
    input  logic                report_stall,
    output udiv_pkg::udiv_out_t report
);
    import udiv_pkg::*;

    logic     advance;
    logic     item_valid;
    udiv_in_t item;

    udiv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    udiv_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .advance      (advance),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report)
    );

endmodule

@@ design/udiv_in_stage.sv @@
`timescale 1ns / 1ps

module udiv_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  udiv_pkg::udiv_in_t byte_data,
    input  logic              advance,
    output logic              item_valid,
    output udiv_pkg::udiv_in_t item
);
    import udiv_pkg::*;

    logic     item_valid_reg;
    udiv_in_t item_reg;

    assign byte_stall = item_valid_reg && !advance;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            item_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            item_reg <= byte_data;
        end
    end

endmodule

@@ design/udiv_core.sv @@
`timescale 1ns / 1ps

module udiv_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  udiv_pkg::udiv_in_t item,
    output logic               advance,
    output logic               report_valid,
    input  logic               report_stall,
    output udiv_pkg::udiv_out_t report
);
    import udiv_pkg::*;

    logic [4:0]  pos_reg;
    logic [31:0] crc_reg;
    logic        magic_reg;
    logic [7:0]  delay_reg [4];
    logic [7:0]  version_reg;
    logic [7:0]  cyl_reg;
    logic [7:0]  side_reg;
    logic [31:0] size_reg;
    logic        report_valid_reg;
    udiv_out_t   report_reg;

    logic        finish;
    logic        magic_next;
    logic [31:0] crc_next;
    logic [31:0] stored;
    udiv_status_t status_next;
    udiv_out_t   report_next;

    assign advance = item_valid && (!item.last_byte || !report_valid_reg || !report_stall);
    assign finish  = advance && item.last_byte;

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

    always_comb
    begin
        magic_next = magic_reg;
        if (pos_reg < POS_SIZE && item.data_byte != magic_byte(pos_reg[1:0]))
        begin
            magic_next = 1'b0;
        end
        crc_next = (pos_reg >= POS_SIZE) ? crc_byte(crc_reg, delay_reg[0]) : crc_reg;
        stored   = {item.data_byte, delay_reg[3], delay_reg[2], delay_reg[1]};

        if (pos_reg < POS_SHORT)
            status_next = ST_SHORT;
        else if (!magic_next)
            status_next = ST_BAD_MAGIC;
        else if (stored == crc_next)
            status_next = ST_GOOD;
        else
            status_next = ST_MISMATCH;

        report_next        = '0;
        report_next.status = status_next;
        if (status_next == ST_GOOD || status_next == ST_MISMATCH)
        begin
            report_next.format_version    = version_reg;
            report_next.cylinder_count    = cyl_reg + 8'd1;
            report_next.side_count        = side_reg + 8'd1;
            report_next.declared_size     = size_reg;
            report_next.checksum_stored   = stored;
            report_next.checksum_computed = crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            crc_reg          <= CRC_ONES;
            magic_reg        <= 1'b1;
            report_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                pos_reg   <= '0;
                crc_reg   <= CRC_ONES;
                magic_reg <= 1'b1;
            end
            else if (advance)
            begin
                if (pos_reg < POS_MAX)
                    pos_reg <= pos_reg + 5'd1;
                crc_reg   <= crc_next;
                magic_reg <= magic_next;
            end

            if (finish)
                report_valid_reg <= 1'b1;
            else if (!report_stall)
                report_valid_reg <= 1'b0;
        end
    end

    // header holds and delay line
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            delay_reg[0] <= delay_reg[1];
            delay_reg[1] <= delay_reg[2];
            delay_reg[2] <= delay_reg[3];
            delay_reg[3] <= item.data_byte;
            if (pos_reg >= POS_SIZE && pos_reg < POS_VERSION)
            begin
                case (pos_reg[1:0])
                    2'd0:    size_reg[7:0]   <= item.data_byte;
                    2'd1:    size_reg[15:8]  <= item.data_byte;
                    2'd2:    size_reg[23:16] <= item.data_byte;
                    default: size_reg[31:24] <= item.data_byte;
                endcase
            end
            if (pos_reg == POS_VERSION)
                version_reg <= item.data_byte;
            if (pos_reg == POS_CYL)
                cyl_reg <= item.data_byte;
            if (pos_reg == POS_SIDE)
                side_reg <= item.data_byte;
        end
        if (finish)
        begin
            report_reg <= report_next;
        end
    end

endmodule

@@ design/udiv_checker.sv @@
`timescale 1ns / 1ps

module udiv_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_stall,
    input logic                report_valid,
    input logic                report_stall,
    input udiv_pkg::udiv_out_t report
);
    import udiv_pkg::*;

    logic err_status;
    assign err_status = (report.status == ST_SHORT) || (report.status == ST_BAD_MAGIC);

    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report_stall |=> report_valid && $stable(report))
        else $error("stalled report changed");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && err_status |->
            report.format_version == 8'd0 && report.cylinder_count == 8'd0 &&
            report.side_count == 8'd0 && report.declared_size == 32'd0 &&
            report.checksum_stored == 32'd0 && report.checksum_computed == 32'd0)
        else $error("error report carries nonzero fields");

    a_crc_status: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !err_status |->
            ((report.checksum_stored == report.checksum_computed) ==
             (report.status == ST_GOOD)))
        else $error("status disagrees with checksum compare");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> byte_valid || (report_valid && report_stall))
        else $error("input stalled without a blocked report");

    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> report_valid && report_stall)
        else $error("input stalled while the report side is free");

endmodule

bind udi_image_verifier udiv_checker u_checker (.*);

@@ tb/udi_image_verifier_test.sv @@
`timescale 1ns / 1ps

module udi_image_verifier_test;
    import udiv_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 750;
    localparam int DIR_N        = 22;

    localparam logic [7:0] MAGIC_SEQ [4] = '{8'h55, 8'h44, 8'h49, 8'h21};

    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         typed;
        udiv_status_t want;
    } dir_row_t;

    // single-byte images, then a minimum-length image with a broken magic
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{8'h00, 1'b1, 1'b1, ST_SHORT},
        '{8'hFF, 1'b1, 1'b1, ST_SHORT},
        '{8'h55, 1'b0, 1'b0, ST_GOOD},
        '{8'h44, 1'b0, 1'b0, ST_GOOD},
        '{8'h49, 1'b0, 1'b0, ST_GOOD},
        '{8'h20, 1'b0, 1'b0, ST_GOOD},
        '{8'hFF, 1'b0, 1'b0, ST_GOOD},
        '{8'hFF, 1'b0, 1'b0, ST_GOOD},
        '{8'hFF, 1'b0, 1'b0, ST_GOOD},
        '{8'hFF, 1'b0, 1'b0, ST_GOOD},
        '{8'hFF, 1'b0, 1'b0, ST_GOOD},
        '{8'hFF, 1'b0, 1'b0, ST_GOOD},
        '{8'hFF, 1'b0, 1'b0, ST_GOOD},
        '{8'h00, 1'b0, 1'b0, ST_GOOD},
        '{8'h00, 1'b0, 1'b0, ST_GOOD},
        '{8'h00, 1'b0, 1'b0, ST_GOOD},
        '{8'h00, 1'b0, 1'b0, ST_GOOD},
        '{8'h00, 1'b0, 1'b0, ST_GOOD},
        '{8'h00, 1'b0, 1'b0, ST_GOOD},
        '{8'h00, 1'b0, 1'b0, ST_GOOD},
        '{8'h00, 1'b0, 1'b0, ST_GOOD},
        '{8'hFF, 1'b1, 1'b1, ST_BAD_MAGIC}
    };

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    udiv_in_t  byte_data;
    logic      report_valid;
    logic      report_stall;
    udiv_out_t report;

    // travels alongside byte_data: a typed-in expectation for that transaction
    logic      row_typed;
    udiv_out_t row_expect;

    bit        gap_on;
    bit        stall_on;
    int        errors;
    int        bytes_sent;
    int        images_sent;
    int        status_seen [4];
    udiv_out_t pending_reports [$];
    logic [7:0] image_bytes [$];

    // image tracker state
    logic [4:0]  img_pos;
    logic [7:0]  tail [4];
    logic [31:0] crc_acc;
    bit          magic_ok;
    logic [7:0]  ver_q;
    logic [7:0]  cyl_q;
    logic [7:0]  side_q;
    logic [31:0] size_q;

    udi_image_verifier u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [31:0] crc_next(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = ~acc ^ {24'd0, b};
        repeat (8)
        begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
        end
        return ~r;
    endfunction

    task automatic clear_image();
        img_pos  = '0;
        tail     = '{default: 8'h00};
        crc_acc  = CRC_ONES;
        magic_ok = 1'b1;
        ver_q    = '0;
        cyl_q    = '0;
        side_q   = '0;
        size_q   = '0;
    endtask

    task automatic advance_image(input udiv_in_t it, output bit fin, output udiv_out_t r);
        logic [4:0]  pos;
        logic [31:0] stored;
        int          sh;
        pos = img_pos;
        fin = 1'b0;
        r   = '0;
        if (pos < POS_SIZE)
        begin
            if (it.data_byte != MAGIC_SEQ[pos[1:0]])
                magic_ok = 1'b0;
        end
        else if (pos < POS_VERSION)
        begin
            sh = 8 * (int'(pos) - int'(POS_SIZE));
            size_q[sh +: 8] = it.data_byte;
        end
        else if (pos == POS_VERSION)
            ver_q = it.data_byte;
        else if (pos == POS_CYL)
            cyl_q = it.data_byte;
        else if (pos == POS_SIDE)
            side_q = it.data_byte;

        if (pos >= POS_SIZE)
            crc_acc = crc_next(crc_acc, tail[0]);
        tail[0] = tail[1];
        tail[1] = tail[2];
        tail[2] = tail[3];
        tail[3] = it.data_byte;
        if (pos < POS_MAX)
            img_pos = pos + 5'd1;

        if (it.last_byte)
        begin
            fin = 1'b1;
            stored = {tail[3], tail[2], tail[1], tail[0]};
            if (pos < POS_SHORT)
                r.status = ST_SHORT;
            else if (!magic_ok)
                r.status = ST_BAD_MAGIC;
            else
            begin
                r.status            = (stored == crc_acc) ? ST_GOOD : ST_MISMATCH;
                r.format_version    = ver_q;
                r.cylinder_count    = cyl_q + 8'd1;
                r.side_count        = side_q + 8'd1;
                r.declared_size     = size_q;
                r.checksum_stored   = stored;
                r.checksum_computed = crc_acc;
            end
            clear_image();
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        errors++;
        $display("ERROR %0t ns: %s got %08h expected %08h", $time, what, got, want);
    endtask

    task automatic send_byte(input udiv_in_t it, input logic typed, input udiv_out_t ex);
        int gap;
        gap = gap_on ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= it;
        row_typed  <= typed;
        row_expect <= ex;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // mostly well-formed images: right magic, sometimes the right checksum
    task automatic build_image();
        int          kind;
        int          len;
        int          p;
        logic [31:0] acc;
        image_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 12)
            len = $urandom_range(1, 19);
        else if (kind < 16)
            len = $urandom_range(60, 120);
        else
            len = $urandom_range(20, 32);
        repeat (len) image_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) != 0)
            for (p = 0; p < 4 && p < len; p++)
                image_bytes[p] = MAGIC_SEQ[p];
        if ($urandom_range(0, 9) == 0)
        begin
            p = $urandom_range(0, 3);
            if (p < len)
                image_bytes[p] = image_bytes[p] ^ 8'(1 << $urandom_range(0, 7));
        end
        if (len > int'(POS_SIDE) && $urandom_range(0, 3) == 0)
            for (p = int'(POS_SIZE); p <= int'(POS_SIDE); p++)
                image_bytes[p] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if (len >= int'(POS_MAX) && $urandom_range(0, 2) != 0)
        begin
            acc = CRC_ONES;
            for (p = 0; p < len - 4; p++)
                acc = crc_next(acc, image_bytes[p]);
            for (p = 0; p < 4; p++)
                image_bytes[len - 4 + p] = acc[8 * p +: 8];
        end
    endtask

    always @(posedge clk)
    begin : monitor
        udiv_out_t want_r;
        udiv_out_t rpt;
        bit        fin;
        if (rst_n)
        begin
            if (report_valid && !report_stall)
            begin
                if (pending_reports.size() == 0)
                    note_mismatch("report with nothing pending", 32'(report.status), '0);
                else
                begin
                    want_r = pending_reports.pop_front();
                    status_seen[int'(want_r.status)]++;
                    if (report.status !== want_r.status)
                        note_mismatch("status", 32'(report.status), 32'(want_r.status));
                    if (report.format_version !== want_r.format_version)
                        note_mismatch("format_version", 32'(report.format_version),
                                      32'(want_r.format_version));
                    if (report.cylinder_count !== want_r.cylinder_count)
                        note_mismatch("cylinder_count", 32'(report.cylinder_count),
                                      32'(want_r.cylinder_count));
                    if (report.side_count !== want_r.side_count)
                        note_mismatch("side_count", 32'(report.side_count),
                                      32'(want_r.side_count));
                    if (report.declared_size !== want_r.declared_size)
                        note_mismatch("declared_size", report.declared_size,
                                      want_r.declared_size);
                    if (report.checksum_stored !== want_r.checksum_stored)
                        note_mismatch("checksum_stored", report.checksum_stored,
                                      want_r.checksum_stored);
                    if (report.checksum_computed !== want_r.checksum_computed)
                        note_mismatch("checksum_computed", report.checksum_computed,
                                      want_r.checksum_computed);
                end
            end
            if (byte_valid && !byte_stall)
            begin
                advance_image(byte_data, fin, rpt);
                if (fin)
                    pending_reports.push_back(row_typed ? row_expect : rpt);
            end
        end
    end

    // report side: hold each report off for a drawn number of valid cycles
    initial
    begin : report_sink
        int n;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            n = stall_on ? $urandom_range(0, 15) : 0;
            if (n != 0)
                report_stall <= 1'b1;
            while (n != 0)
            begin
                @(posedge clk);
                if (report_valid)
                    n--;
            end
            report_stall <= 1'b0;
            @(posedge clk);
            while (!(report_valid && !report_stall))
                @(posedge clk);
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d reports pending",
                 CYCLE_LIMIT, pending_reports.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int        i;
        int        k;
        int        mode;
        udiv_in_t  it;
        udiv_out_t ex;
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        byte_data    = '0;
        report_stall = 1'b0;
        row_typed    = 1'b0;
        row_expect   = '0;
        clear_image();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_N; i++)
        begin
            gap_on   = $urandom_range(0, 1);
            stall_on = $urandom_range(0, 1);
            it.data_byte = DIR_ROWS[i].data;
            it.last_byte = DIR_ROWS[i].last;
            ex = '0;
            ex.status = DIR_ROWS[i].want;
            send_byte(it, DIR_ROWS[i].typed, ex);
        end

        while (bytes_sent < DIR_N + RANDOM_BYTES)
        begin
            build_image();
            mode     = $urandom_range(0, 3);
            gap_on   = mode[0];
            stall_on = mode[1];
            for (k = 0; k < image_bytes.size(); k++)
            begin
                it.data_byte = image_bytes[k];
                it.last_byte = (k == image_bytes.size() - 1);
                send_byte(it, 1'b0, '0);
            end
            images_sent++;
        end
        byte_valid <= 1'b0;

        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Streamed %0d bytes in %0d random images plus the directed table",
                 bytes_sent, images_sent);
        $display("Reports: %0d good, %0d mismatch, %0d short, %0d bad magic; %0d errors",
                 status_seen[ST_GOOD], status_seen[ST_MISMATCH], status_seen[ST_SHORT],
                 status_seen[ST_BAD_MAGIC], errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
